>>> sv/u8v_pkg.sv
package u8v_pkg;

	// Default width of the byte offset counters
	localparam int unsigned OFFSET_BITS_DEF = 32;

	// Width of the offset reported on the result channel
	localparam int unsigned REPORT_BITS = 32;

	// Result queue geometry
	localparam int unsigned QUEUE_DEPTH    = 2;
	localparam int unsigned QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// Byte class boundaries
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_LO    = 8'hC2;
	localparam logic [7:0] LEAD2_HI    = 8'hDF;
	localparam logic [7:0] LEAD3_LO    = 8'hE0;
	localparam logic [7:0] LEAD3_HI    = 8'hEF;
	localparam logic [7:0] LEAD4_LO    = 8'hF0;
	localparam logic [7:0] LEAD4_HI    = 8'hF4;
	localparam logic [7:0] CONT_LO     = 8'h80;
	localparam logic [7:0] CONT_HI     = 8'hBF;

	// Leads that narrow the range of the second byte
	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F4 = 8'hF4;
	localparam logic [7:0] E0_SECOND_LO = 8'hA0;
	localparam logic [7:0] ED_SECOND_HI = 8'h9F;
	localparam logic [7:0] F0_SECOND_LO = 8'h90;
	localparam logic [7:0] F4_SECOND_HI = 8'h8F;

	// One result beat
	typedef struct packed {
		logic                   buffer_ok;
		logic [REPORT_BITS-1:0] scan_offset;
		logic                   truncated;
		logic [1:0]             bad_len;
	} res_t;

	// Head of the result queue as seen by the output stage
	typedef struct packed {
		logic avail;
		res_t data;
	} q_head_t;

endpackage

>>> sv/u8v_stream_if.sv
interface u8v_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8v_result_if;
	logic        valid;
	logic        ready;
	logic        buffer_ok;
	logic [31:0] scan_offset;
	logic        truncated;
	logic [1:0]  bad_len;

	modport source (output valid, output buffer_ok, output scan_offset, output truncated,
		output bad_len, input ready);
	modport sink (input valid, input buffer_ok, input scan_offset, input truncated,
		input bad_len, output ready);
endinterface

>>> sv/u8v_front.sv
module u8v_front #(
	parameter int unsigned OFFSET_BITS = u8v_pkg::OFFSET_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	u8v_byte_if.sink      bytes,
	input  logic          q_full,
	output logic          push,
	output u8v_pkg::res_t push_data
);
	import u8v_pkg::*;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

	logic [OFFSET_BITS-1:0] off_q;
	logic [OFFSET_BITS-1:0] seq_start_q;
	logic [1:0]             rem_q;
	logic [1:0]             pos_q;
	logic [7:0]             lead_q;
	logic                   err_rep_q;

	logic                   accept;
	logic [7:0]             b;
	logic                   last;
	logic [OFFSET_BITS-1:0] next_pos;
	logic [OFFSET_BITS-1:0] seq_n;
	logic [1:0]             rem_n;
	logic [1:0]             pos_n;
	logic [7:0]             lead_n;
	logic                   err;
	logic [OFFSET_BITS-1:0] err_at;
	logic [1:0]             err_len;
	logic [7:0]             lo;
	logic [7:0]             hi;
	logic [OFFSET_BITS-1:0] rep_src;
	logic [REPORT_BITS-1:0] rep_off;

	// Take a beat whenever the queue has room
	assign bytes.ready = !q_full;
	assign accept      = bytes.valid && bytes.ready;
	assign b           = bytes.data_byte;
	assign last        = bytes.last_byte;

	// Advance the offset, saturating at the top
	assign next_pos = (off_q == OFF_MAX) ? off_q : off_q + OFFSET_BITS'(1);

	// Bounds of the expected continuation byte
	always_comb begin
		lo = CONT_LO;
		hi = CONT_HI;
		if (pos_q == 2'd1) begin
			case (lead_q)
				LEAD_E0: lo = E0_SECOND_LO;
				LEAD_ED: hi = ED_SECOND_HI;
				LEAD_F0: lo = F0_SECOND_LO;
				LEAD_F4: hi = F4_SECOND_HI;
				default: ;
			endcase
		end
	end

	// Classify the byte and compute the sequence state it leaves
	always_comb begin
		rem_n   = rem_q;
		pos_n   = pos_q;
		lead_n  = lead_q;
		seq_n   = seq_start_q;
		err     = 1'b0;
		err_at  = off_q;
		err_len = 2'd0;
		if (rem_q == 2'd0) begin
			if (b < ASCII_LIMIT) begin
				rem_n = 2'd0;
			end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
				rem_n = 2'd1;
			end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
				rem_n = 2'd2;
			end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
				rem_n = 2'd3;
			end else begin
				err     = 1'b1;
				err_len = 2'd1;
			end
			if (!err && rem_n != 2'd0) begin
				pos_n  = 2'd1;
				lead_n = b;
				seq_n  = off_q;
			end
		end else if (b < lo || b > hi) begin
			err     = 1'b1;
			err_at  = seq_start_q;
			err_len = pos_q;
		end else begin
			rem_n = rem_q - 2'd1;
			pos_n = (rem_q == 2'd1) ? 2'd0 : pos_q + 2'd1;
		end
	end

	// Pick the offset to report and clamp it to the report width
	assign rep_src = err ? err_at : ((rem_n != 2'd0) ? seq_n : next_pos);

	generate
		if (OFFSET_BITS > REPORT_BITS) begin : g_clamp
			assign rep_off = (|rep_src[OFFSET_BITS-1:REPORT_BITS]) ? '1
				: rep_src[REPORT_BITS-1:0];
		end else begin : g_extend
			assign rep_off = REPORT_BITS'(rep_src);
		end
	endgenerate

	// Emit one result at the first error or at the end of the buffer
	assign push                  = accept && !err_rep_q && (err || last);
	assign push_data.buffer_ok   = !err && (rem_n == 2'd0);
	assign push_data.truncated   = !err && (rem_n != 2'd0);
	assign push_data.bad_len     = err ? err_len : 2'd0;
	assign push_data.scan_offset = rep_off;

	// Update the buffer state; drop it at the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q       <= '0;
			seq_start_q <= '0;
			rem_q       <= '0;
			pos_q       <= '0;
			lead_q      <= '0;
			err_rep_q   <= 1'b0;
		end else if (accept) begin
			if (last) begin
				off_q       <= '0;
				seq_start_q <= '0;
				rem_q       <= '0;
				pos_q       <= '0;
				lead_q      <= '0;
				err_rep_q   <= 1'b0;
			end else if (!err_rep_q) begin
				off_q       <= next_pos;
				seq_start_q <= seq_n;
				rem_q       <= rem_n;
				pos_q       <= pos_n;
				lead_q      <= lead_n;
				err_rep_q   <= err;
			end
		end
	end

`ifndef SYNTHESIS
	a_quiet_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		err_rep_q |-> !push)
		else $error("result pushed after an error was already reported");
	a_seq_counts_agree: assert property (@(posedge clk) disable iff (!arst_n)
		((rem_q == 2'd0) == (pos_q == 2'd0)))
		else $error("remaining and position counts disagree");
	a_mid_error_marks: assert property (@(posedge clk) disable iff (!arst_n)
		push && !last |=> err_rep_q)
		else $error("error before the last beat did not set the error flag");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> (off_q == '0) && !err_rep_q && (rem_q == 2'd0))
		else $error("state not cleared after the last beat");
`endif

endmodule

>>> sv/u8v_fifo.sv
module u8v_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u8v_pkg::res_t    push_data,
	input  logic             pop,
	output logic             full,
	output u8v_pkg::q_head_t head
);
	import u8v_pkg::*;

	res_t                      mem_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_BITS-1:0] wr_ptr_q;
	logic [QUEUE_IDX_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] cnt_q;

	assign full       = (cnt_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign head.avail = (cnt_q != '0);
	assign head.data  = mem_q[rd_ptr_q];

	// Store the pushed result
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_IDX_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_IDX_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QUEUE_CNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QUEUE_CNT_BITS'(1);
			end
		end
	end

endmodule

>>> sv/u8v_back.sv
module u8v_back (
	input  logic             clk,
	input  logic             arst_n,
	input  u8v_pkg::q_head_t head,
	output logic             pop,
	u8v_result_if.source     results
);
	import u8v_pkg::*;

	logic valid_q;
	res_t data_q;

	// Load the output register when it is empty or being drained
	assign pop = head.avail && (!valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Hold the payload until the beat is taken
	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head.data;
		end
	end

	assign results.valid       = valid_q;
	assign results.buffer_ok   = data_q.buffer_ok;
	assign results.scan_offset = data_q.scan_offset;
	assign results.truncated   = data_q.truncated;
	assign results.bad_len     = data_q.bad_len;

endmodule

>>> sv/utf8_stream_validator_core.sv
// Channel   Dir  Payload                                      Handshake
// bytes     in   data_byte[7:0], last_byte                    valid / ready
// results   out  buffer_ok, scan_offset[31:0], truncated,     valid / ready
//                bad_len[1:0]
//
// One byte is taken per clock; each beat is classified in the same cycle it is
// accepted, so the byte loop runs at one beat per cycle.
// A result enters a two-entry queue at the edge that accepts its byte, and
// moves to the registered output stage when it is empty or being drained.
// The byte side stalls only when the queue is full; reset is asynchronous
// and returns the validator to the start of a buffer with nothing queued.
module utf8_stream_validator_core #(
	parameter int unsigned OFFSET_BITS = u8v_pkg::OFFSET_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	u8v_byte_if.sink     bytes,
	u8v_result_if.source results
);
	import u8v_pkg::*;

	logic    push;
	res_t    push_data;
	logic    pop;
	logic    q_full;
	q_head_t head;

	// Classify bytes and track the open sequence
	u8v_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	// Queue results between the two sides
	u8v_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (q_full),
		.head     (head)
	);

	// Drive the result channel
	u8v_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.results(results)
	);

endmodule
